[design/stl_pkg.sv]
`default_nettype none

package stl_pkg;

  // Table geometry and data widths.
  localparam int TABLE_POINTS_DEF = 16;
  localparam int DATA_W           = 16;

  // Engineering value that marks an invalid conversion.
  localparam logic [DATA_W-1:0] INVALID_VALUE = 16'hFFFF;

  // Item commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_RES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_VOLT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_KIND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE   = 3'd5;

  // Signal kinds.
  localparam logic [1:0] KIND_RES  = 2'd0;
  localparam logic [1:0] KIND_VOLT = 2'd1;

endpackage

`default_nettype wire

[design/sensor_table_linearizer_core.sv]
`default_nettype none
// A load item writes its table entry and gives no result; the block stays idle for the next item.
// A convert item reads the last and first entries, divides for voltage or resistor mode,
// scans k < TABLE_POINTS entries and divides once more when interpolation needs a division.
// One convert item is taken at a time; a new item is taken only once its result has entered
// the output register. The divider is a radix-4 one and the table has one read port.
// Reset (rst_n low, synchronous) clears control and configuration; tables stay undefined.
module sensor_table_linearizer_core #(
  parameter int TABLE_POINTS = stl_pkg::TABLE_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Item input channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_command,
  input  wire logic [3:0]                    in_entry_index,
  input  wire logic [stl_pkg::DATA_W-1:0]    in_meter_point,
  input  wire logic [stl_pkg::DATA_W-1:0]    in_engin_point,
  input  wire logic [stl_pkg::DATA_W-1:0]    in_sample,
  // Result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [stl_pkg::DATA_W-1:0]    out_eng_value,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [stl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stl_pkg::DATA_W-1:0]    cfg_data
);

  localparam int IW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_POINTS - 1);
  localparam logic [IW-1:0] FIRST_SEARCH_ADDR = IW'(1);

  // Quotient bit pairs produced by the divider for each kind of division.
  localparam logic [4:0] RES_PAIRS    = 5'd9;   // 18-bit resistance quotient
  localparam logic [4:0] VOLT_PAIRS   = 5'd8;   // 16-bit voltage quotient
  localparam logic [4:0] INTERP_PAIRS = 5'd16;  // 32-bit interpolation quotient

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RDLAST = 11'b000_0000_0010,
    S_RD0    = 11'b000_0000_0100,
    S_MUL    = 11'b000_0000_1000,
    S_PREP   = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_QUO    = 11'b000_0100_0000,
    S_RANGE  = 11'b000_1000_0000,
    S_SEARCH = 11'b001_0000_0000,
    S_MUL3   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  // One restoring division step: shifts one dividend bit into the partial
  // remainder and returns {quotient bit, new remainder}.
  function automatic logic [32:0] div_step(input logic [31:0] rem,
                                           input logic        dbit,
                                           input logic [31:0] dvs);
    logic [32:0] trial;
    logic [32:0] diff;
    trial = {rem, dbit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[31:0]};
    end else begin
      div_step = {1'b0, trial[31:0]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. The port is always ready; the user must write
  // only while the block is idle, which the block itself does not enforce.
  // ---------------------------------------------------------------------------
  logic [15:0] ref_res_r;
  logic [15:0] ref_volt_r;
  logic [15:0] volt_gain_r;
  logic [15:0] adc_gain_r;
  logic [1:0]  sig_kind_r;
  logic        inverse_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_res_r   <= '0;
      ref_volt_r  <= '0;
      volt_gain_r <= 16'd1;
      adc_gain_r  <= 16'd1;
      sig_kind_r  <= stl_pkg::KIND_RES;
      inverse_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stl_pkg::REG_REF_RES:   ref_res_r   <= cfg_data;
        stl_pkg::REG_REF_VOLT:  ref_volt_r  <= cfg_data;
        stl_pkg::REG_VOLT_GAIN: volt_gain_r <= cfg_data;
        stl_pkg::REG_ADC_GAIN:  adc_gain_r  <= cfg_data;
        stl_pkg::REG_SIG_KIND:  sig_kind_r  <= cfg_data[1:0];
        stl_pkg::REG_INVERSE:   inverse_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: each word holds {meter value, engineering value}. A load
  // writes in the cycle it is accepted, so a convert accepted in the next
  // cycle already reads the new contents; no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [31:0]   tbl_mem [TABLE_POINTS];
  logic [31:0]   rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          tbl_we;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[IW'(in_entry_index)] <= {in_meter_point, in_engin_point};
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [15:0] s_r,    s_nxt;
  logic [15:0] ml_r,   ml_nxt;
  logic [15:0] el_r,   el_nxt;
  logic [15:0] m0_r,   m0_nxt;
  logic [15:0] e0_r,   e0_nxt;
  logic [15:0] mp_r,   mp_nxt;
  logic [15:0] ep_r,   ep_nxt;
  logic [16:0] x_r,    x_nxt;
  logic [31:0] vref_r, vref_nxt;
  logic [31:0] vin_r,  vin_nxt;
  logic [47:0] num_r,  num_nxt;
  logic [15:0] dx_r,   dx_nxt;
  logic [15:0] de_r,   de_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] res_r,  res_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  // Divider: partial remainder, divisor, and a dividend register that takes
  // the quotient bits in at its bottom as the dividend bits leave at the top.
  logic [31:0] rem_r,  rem_nxt;
  logic [31:0] dvs_r,  dvs_nxt;
  logic [47:0] dvd_r,  dvd_nxt;
  logic [4:0]  cnt_r,  cnt_nxt;
  logic        interp_r, interp_nxt;
  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_r,  out_nxt;

  logic [32:0] step1;
  logic [32:0] step2;
  logic [16:0] cap;
  logic [15:0] mi;
  logic [15:0] ei;
  logic [15:0] dm;
  logic        out_free;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_eng_value = out_r;
  assign out_free      = !out_valid_r || out_ready;

  // A resistance is clamped at twice the last meter point, kept 17 bits wide.
  assign cap = {ml_r, 1'b0};
  assign mi  = rd_data_r[31:16];
  assign ei  = rd_data_r[15:0];
  assign dm  = mi - mp_r;

  assign step1 = div_step(rem_r, dvd_r[47], dvs_r);
  assign step2 = div_step(step1[31:0], dvd_r[46], dvs_r);

  assign tbl_we = in_valid && in_ready && (in_command == stl_pkg::CMD_LOAD) &&
                  (int'(in_entry_index) < TABLE_POINTS);

  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    ml_nxt     = ml_r;
    el_nxt     = el_r;
    m0_nxt     = m0_r;
    e0_nxt     = e0_r;
    mp_nxt     = mp_r;
    ep_nxt     = ep_r;
    x_nxt      = x_r;
    vref_nxt   = vref_r;
    vin_nxt    = vin_r;
    num_nxt    = num_r;
    dx_nxt     = dx_r;
    de_nxt     = de_r;
    base_nxt   = base_r;
    res_nxt    = res_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    dvd_nxt    = dvd_r;
    cnt_nxt    = cnt_r;
    interp_nxt = interp_r;
    out_nxt    = out_r;
    rd_addr    = LAST_ADDR;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        // The last table entry is read first; it bounds the resistance clamp.
        if (in_valid && (in_command == stl_pkg::CMD_CONVERT)) begin
          s_nxt     = in_sample;
          state_nxt = S_RDLAST;
        end
      end

      S_RDLAST: begin
        ml_nxt    = rd_data_r[31:16];
        el_nxt    = rd_data_r[15:0];
        rd_addr   = '0;
        state_nxt = S_RD0;
      end

      S_RD0: begin
        m0_nxt = rd_data_r[31:16];
        e0_nxt = rd_data_r[15:0];
        unique case (sig_kind_r)
          stl_pkg::KIND_RES: begin
            vref_nxt  = {16'b0, ref_volt_r} * {16'b0, adc_gain_r};
            vin_nxt   = {16'b0, s_r} * {16'b0, volt_gain_r};
            state_nxt = S_MUL;
          end
          stl_pkg::KIND_VOLT: begin
            if (ref_res_r == '0) begin
              res_nxt   = stl_pkg::INVALID_VALUE;
              state_nxt = S_DONE;
            end else begin
              rem_nxt    = '0;
              dvd_nxt    = {s_r, 32'b0};
              dvs_nxt    = {16'b0, ref_res_r};
              cnt_nxt    = VOLT_PAIRS;
              interp_nxt = 1'b0;
              state_nxt  = S_DIV;
            end
          end
          default: begin
            res_nxt   = stl_pkg::INVALID_VALUE;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_MUL: begin
        // The divider denominator must be positive.
        if (vin_r >= vref_r) begin
          res_nxt   = stl_pkg::INVALID_VALUE;
          state_nxt = S_DONE;
        end else begin
          num_nxt   = {16'b0, vin_r} * {32'b0, ref_res_r};
          dvs_nxt   = vref_r - vin_r;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        // A quotient of 2^17 or more is always clamped, so only its low 18
        // bits are divided out; the upper dividend bits start the remainder.
        if ({1'b0, num_r} >= {dvs_r, 17'b0}) begin
          x_nxt     = cap;
          state_nxt = S_RANGE;
        end else begin
          rem_nxt    = {2'b0, num_r[47:18]};
          dvd_nxt    = {num_r[17:0], 30'b0};
          cnt_nxt    = RES_PAIRS;
          interp_nxt = 1'b0;
          state_nxt  = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = step2[31:0];
        dvd_nxt = {dvd_r[45:0], step1[32], step2[32]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = S_QUO;
        end
      end

      S_QUO: begin
        if (interp_r) begin
          res_nxt   = base_r + dvd_r[15:0];
          state_nxt = S_DONE;
        end else begin
          if (sig_kind_r == stl_pkg::KIND_VOLT) begin
            x_nxt = {1'b0, dvd_r[15:0]};
          end else if (dvd_r[17:0] >= {1'b0, cap}) begin
            x_nxt = cap;
          end else begin
            x_nxt = dvd_r[16:0];
          end
          state_nxt = S_RANGE;
        end
      end

      S_RANGE: begin
        priority if (x_r <= {1'b0, m0_r}) begin
          res_nxt   = (x_r < {2'b0, m0_r[15:1]}) ? stl_pkg::INVALID_VALUE : e0_r;
          state_nxt = S_DONE;
        end else if (x_r > {1'b0, ml_r}) begin
          res_nxt   = (x_r >= cap) ? stl_pkg::INVALID_VALUE : el_r;
          state_nxt = S_DONE;
        end else begin
          mp_nxt    = m0_r;
          ep_nxt    = e0_r;
          idx_nxt   = FIRST_SEARCH_ADDR;
          rd_addr   = FIRST_SEARCH_ADDR;
          state_nxt = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // The scan always stops by the last entry since x does not exceed it.
        priority if (x_r == {1'b0, mi}) begin
          res_nxt   = ei;
          state_nxt = S_DONE;
        end else if (x_r < {1'b0, mi}) begin
          if (inverse_r) begin
            dx_nxt   = mi - x_r[15:0];
            de_nxt   = ep_r - ei;
            base_nxt = ei;
          end else begin
            dx_nxt   = x_r[15:0] - mp_r;
            de_nxt   = ei - ep_r;
            base_nxt = ep_r;
          end
          if (dm == '0) begin
            res_nxt   = base_nxt;
            state_nxt = S_DONE;
          end else begin
            dvs_nxt   = {16'b0, dm};
            state_nxt = S_MUL3;
          end
        end else begin
          mp_nxt  = mi;
          ep_nxt  = ei;
          idx_nxt = idx_r + IW'(1);
          rd_addr = idx_r + IW'(1);
        end
      end

      S_MUL3: begin
        rem_nxt    = '0;
        dvd_nxt    = {{16'b0, dx_r} * {16'b0, de_r}, 16'b0};
        cnt_nxt    = INTERP_PAIRS;
        interp_nxt = 1'b1;
        state_nxt  = S_DIV;
      end

      S_DONE: begin
        // The result waits here only while the output register is still full.
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      interp_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      interp_r    <= interp_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    ml_r   <= ml_nxt;
    el_r   <= el_nxt;
    m0_r   <= m0_nxt;
    e0_r   <= e0_nxt;
    mp_r   <= mp_nxt;
    ep_r   <= ep_nxt;
    x_r    <= x_nxt;
    vref_r <= vref_nxt;
    vin_r  <= vin_nxt;
    num_r  <= num_nxt;
    dx_r   <= dx_nxt;
    de_r   <= de_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    dvd_r  <= dvd_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

[design/stl_checker.sv]
`default_nettype none

module stl_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_command,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [stl_pkg::DATA_W-1:0]    out_eng_value
);

  // Reset empties the output and opens the input.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A convert item owns the block until its result is produced.
  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == stl_pkg::CMD_CONVERT) |=> !in_ready)
    else $error("input accepted again right after a convert item");

  // A load item never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == stl_pkg::CMD_LOAD) && !out_valid
    |=> !out_valid)
    else $error("result appeared after a load item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_eng_value))
    else $error("stalled result changed or dropped");

endmodule

bind sensor_table_linearizer_core stl_checker u_stl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_eng_value (out_eng_value)
);

`default_nettype wire
